>>> rtl/slri_pkg.sv
// Package for the sorted list rank-and-insert block.
// Holds parameter defaults and the fixed field widths of the stream ports.
// No dependencies.
package slri_pkg;

  localparam int unsigned CapacityDef  = 1024;
  localparam int unsigned ValueBitsDef = 32;

  localparam int unsigned InDataW  = 32;
  localparam int unsigned RankW    = 11;
  localparam int unsigned SlotOutW = 10;
  localparam int unsigned OutDataW = RankW + 1 + SlotOutW + SlotOutW;

endpackage

>>> rtl/slri_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module slri_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/slri_ctrl.sv
// Walk and link sequencer of the sorted list rank-and-insert block.
// Drives the value and link memories and holds the result register.
// Depends on slri_pkg.
module slri_ctrl #(
  parameter int unsigned CAPACITY   = slri_pkg::CapacityDef,
  parameter int unsigned VALUE_BITS = slri_pkg::ValueBitsDef,
  localparam int unsigned SlotW     = $clog2(CAPACITY),
  localparam int unsigned LinkW     = $clog2(CAPACITY + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [slri_pkg::InDataW-1:0]  in_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [slri_pkg::RankW-1:0]    out_rank_o,
  output logic                          out_at_head_o,
  output logic [slri_pkg::SlotOutW-1:0] out_pred_slot_o,
  output logic [slri_pkg::SlotOutW-1:0] out_new_slot_o,
  output logic                          out_full_error_o,
  output logic                          rd_en_o,
  output logic [SlotW-1:0]              rd_addr_o,
  input  logic [VALUE_BITS-1:0]         val_rdata_i,
  input  logic [LinkW-1:0]              link_rdata_i,
  output logic                          val_we_o,
  output logic [SlotW-1:0]              val_waddr_o,
  output logic [VALUE_BITS-1:0]         val_wdata_o,
  output logic                          link_we_o,
  output logic [SlotW-1:0]              link_waddr_o,
  output logic [LinkW-1:0]              link_wdata_o
);
  import slri_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StWalk = 3'd1;
  localparam logic [2:0] StLink = 3'd2;
  localparam logic [2:0] StTail = 3'd3;
  localparam logic [2:0] StDone = 3'd4;

  localparam logic [LinkW-1:0] CapMark = LinkW'(CAPACITY);

  logic [2:0]            state_q, state_d;
  logic [LinkW-1:0]      fill_q, fill_d;
  logic [LinkW-1:0]      head_q, head_d;
  logic [VALUE_BITS-1:0] key_q, key_d;
  logic [LinkW-1:0]      cur_q, cur_d;
  logic [SlotW-1:0]      prev_q, prev_d;
  logic                  have_prev_q, have_prev_d;
  logic [LinkW-1:0]      rank_q, rank_d;
  logic [LinkW-1:0]      steps_q, steps_d;
  logic                  err_q, err_d;
  logic                  out_valid_q, out_valid_d;
  logic [RankW-1:0]      out_rank_q, out_rank_d;
  logic                  out_at_head_q, out_at_head_d;
  logic [SlotOutW-1:0]   out_pred_q, out_pred_d;
  logic [SlotOutW-1:0]   out_new_q, out_new_d;
  logic                  out_err_q, out_err_d;

  logic                  accept;
  logic                  full;
  logic [63:0]           in_ext;
  logic [VALUE_BITS-1:0] in_raw;
  logic [VALUE_BITS-1:0] stored_key;
  logic [VALUE_BITS-1:0] new_key;
  logic                  walk_hit;
  logic [LinkW-1:0]      next_steps;
  logic                  walk_more;
  logic                  out_free;
  logic [LinkW+RankW-1:0]    rank_ext;
  logic [SlotW+SlotOutW-1:0] pred_ext;
  logic [LinkW+SlotOutW-1:0] new_ext;

  assign in_ext = {{(64 - InDataW){in_value_i[InDataW-1]}}, in_value_i};
  assign in_raw = in_ext[VALUE_BITS-1:0];

  assign accept     = in_valid_i && in_ready_o;
  assign full       = (fill_q == CapMark);
  assign stored_key = {~val_rdata_i[VALUE_BITS-1], val_rdata_i[VALUE_BITS-2:0]};
  assign new_key    = {~key_q[VALUE_BITS-1], key_q[VALUE_BITS-2:0]};
  assign walk_hit   = (stored_key < new_key);
  assign next_steps = steps_q + LinkW'(1);
  assign walk_more  = (link_rdata_i < fill_q) && (next_steps < fill_q);
  assign out_free   = !out_valid_q || out_ready_i;

  assign rank_ext = {{RankW{1'b0}}, rank_q};
  assign pred_ext = {{SlotOutW{1'b0}}, prev_q};
  assign new_ext  = {{SlotOutW{1'b0}}, fill_q};

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d       = state_q;
    fill_d        = fill_q;
    head_d        = head_q;
    key_d         = key_q;
    cur_d         = cur_q;
    prev_d        = prev_q;
    have_prev_d   = have_prev_q;
    rank_d        = rank_q;
    steps_d       = steps_q;
    err_d         = err_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    out_rank_d    = out_rank_q;
    out_at_head_d = out_at_head_q;
    out_pred_d    = out_pred_q;
    out_new_d     = out_new_q;
    out_err_d     = out_err_q;
    rd_en_o       = 1'b0;
    rd_addr_o     = head_q[SlotW-1:0];
    val_we_o      = 1'b0;
    val_waddr_o   = fill_q[SlotW-1:0];
    val_wdata_o   = key_q;
    link_we_o     = 1'b0;
    link_waddr_o  = fill_q[SlotW-1:0];
    link_wdata_o  = cur_q;

    case (state_q)
      StIdle: begin
        if (accept) begin
          key_d       = in_raw;
          cur_d       = head_q;
          prev_d      = '0;
          have_prev_d = 1'b0;
          rank_d      = LinkW'(1);
          steps_d     = '0;
          err_d       = full;
          if (full) begin
            state_d = StDone;
          end else if (head_q < fill_q) begin
            rd_en_o = 1'b1;
            state_d = StWalk;
          end else begin
            state_d = StLink;
          end
        end
      end
      StWalk: begin
        if (walk_hit) begin
          rank_d      = rank_q + LinkW'(1);
          prev_d      = cur_q[SlotW-1:0];
          have_prev_d = 1'b1;
          cur_d       = link_rdata_i;
          steps_d     = next_steps;
          if (walk_more) begin
            rd_en_o   = 1'b1;
            rd_addr_o = link_rdata_i[SlotW-1:0];
          end else begin
            state_d = StLink;
          end
        end else begin
          state_d = StLink;
        end
      end
      StLink: begin
        val_we_o  = 1'b1;
        link_we_o = 1'b1;
        if (have_prev_q) begin
          state_d = StTail;
        end else begin
          head_d  = fill_q;
          state_d = StDone;
        end
      end
      StTail: begin
        link_we_o    = 1'b1;
        link_waddr_o = prev_q;
        link_wdata_o = fill_q;
        state_d      = StDone;
      end
      StDone: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_err_d     = err_q;
          out_rank_d    = err_q ? '0 : rank_ext[RankW-1:0];
          out_at_head_d = !err_q && !have_prev_q;
          out_pred_d    = err_q ? '0 : pred_ext[SlotOutW-1:0];
          out_new_d     = err_q ? '0 : new_ext[SlotOutW-1:0];
          if (!err_q) begin
            fill_d = fill_q + LinkW'(1);
          end
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      fill_q      <= '0;
      head_q      <= CapMark;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      head_q      <= head_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q         <= key_d;
    cur_q         <= cur_d;
    prev_q        <= prev_d;
    have_prev_q   <= have_prev_d;
    rank_q        <= rank_d;
    steps_q       <= steps_d;
    err_q         <= err_d;
    out_rank_q    <= out_rank_d;
    out_at_head_q <= out_at_head_d;
    out_pred_q    <= out_pred_d;
    out_new_q     <= out_new_d;
    out_err_q     <= out_err_d;
  end

  assign out_valid_o      = out_valid_q;
  assign out_rank_o       = out_rank_q;
  assign out_at_head_o    = out_at_head_q;
  assign out_pred_slot_o  = out_pred_q;
  assign out_new_slot_o   = out_new_q;
  assign out_full_error_o = out_err_q;

endmodule

>>> rtl/sorted_list_rank_insert.sv
// Sorted list rank-and-insert top level with value and link memories, slri_ctrl and slri_pkg.
// The result beat is offered in the same cycle that the input is ready again.
// One walk step reads both memories once; a value refused with the store full
// skips the walk and the memory writes and goes straight to its result.
// Reset gives an empty list; memory contents are left as they are.
module sorted_list_rank_insert #(
  parameter int unsigned CAPACITY   = slri_pkg::CapacityDef,
  parameter int unsigned VALUE_BITS = slri_pkg::ValueBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // Fields from bit 0: new_value.
  input  logic [slri_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // Fields from bit 0: rank, at_head, pred_slot, new_slot.
  output logic [slri_pkg::OutDataW-1:0] m_axis_tdata,
  // Fields from bit 0: full_error.
  output logic                          m_axis_tuser
);
  import slri_pkg::*;

  localparam int unsigned SlotW = $clog2(CAPACITY);
  localparam int unsigned LinkW = $clog2(CAPACITY + 1);

  logic                  rd_en;
  logic [SlotW-1:0]      rd_addr;
  logic [VALUE_BITS-1:0] val_rdata;
  logic [LinkW-1:0]      link_rdata;
  logic                  val_we;
  logic [SlotW-1:0]      val_waddr;
  logic [VALUE_BITS-1:0] val_wdata;
  logic                  link_we;
  logic [SlotW-1:0]      link_waddr;
  logic [LinkW-1:0]      link_wdata;
  logic [RankW-1:0]      rank;
  logic                  at_head;
  logic [SlotOutW-1:0]   pred_slot;
  logic [SlotOutW-1:0]   new_slot;

  slri_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (CAPACITY)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (val_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (val_rdata)
  );

  slri_ram #(
    .WIDTH (LinkW),
    .DEPTH (CAPACITY)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (link_rdata)
  );

  slri_ctrl #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_o       (s_axis_tready),
    .in_value_i       (s_axis_tdata),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_rank_o       (rank),
    .out_at_head_o    (at_head),
    .out_pred_slot_o  (pred_slot),
    .out_new_slot_o   (new_slot),
    .out_full_error_o (m_axis_tuser),
    .rd_en_o          (rd_en),
    .rd_addr_o        (rd_addr),
    .val_rdata_i      (val_rdata),
    .link_rdata_i     (link_rdata),
    .val_we_o         (val_we),
    .val_waddr_o      (val_waddr),
    .val_wdata_o      (val_wdata),
    .link_we_o        (link_we),
    .link_waddr_o     (link_waddr),
    .link_wdata_o     (link_wdata)
  );

  assign m_axis_tdata = {new_slot, pred_slot, at_head, rank};

endmodule

>>> tb/sv/tb_slri_board_pkg.sv
// Scoreboard for the sorted list rank-and-insert testbench.
// Keeps its own linked list to predict rank, predecessor and slot for each value.
// Depends on slri_pkg for the field widths and the default capacity.
package tb_slri_board_pkg;

  import slri_pkg::*;

  localparam int unsigned Capacity  = CapacityDef;
  localparam int unsigned PrintMax  = 20;

  typedef struct packed {
    logic                full_error;
    logic [SlotOutW-1:0] new_slot;
    logic [SlotOutW-1:0] pred_slot;
    logic                at_head;
    logic [RankW-1:0]    rank;
  } placement_t;

  class list_board;
    logic signed [InDataW-1:0] slot_value [Capacity];
    int unsigned               slot_link  [Capacity];
    int unsigned               head;
    int unsigned               filled;
    placement_t                pending_placements [$];
    int unsigned               errors;
    int unsigned               refusals;
    int unsigned               deepest;

    function new();
      head     = Capacity;
      filled   = 0;
      errors   = 0;
      refusals = 0;
      deepest  = 0;
    endfunction

    function placement_t place_value(logic [InDataW-1:0] raw);
      placement_t                p;
      logic signed [InDataW-1:0] value;
      int unsigned               cur;
      int unsigned               prev;
      int unsigned               rank;
      int unsigned               steps;
      bit                        linked;
      p = '0;
      value = raw;
      if (filled >= Capacity) begin
        p.full_error = 1'b1;
        refusals++;
        return p;
      end
      cur = head;
      prev = 0;
      rank = 1;
      steps = 0;
      linked = 1'b0;
      while (cur < filled && steps < filled && slot_value[cur] < value) begin
        rank++;
        prev = cur;
        linked = 1'b1;
        cur = slot_link[cur];
        steps++;
      end
      slot_value[filled] = value;
      if (linked) begin
        slot_link[filled] = slot_link[prev];
        slot_link[prev] = filled;
      end else begin
        slot_link[filled] = head;
        head = filled;
      end
      p.rank      = rank[RankW-1:0];
      p.at_head   = !linked;
      p.pred_slot = linked ? prev[SlotOutW-1:0] : '0;
      p.new_slot  = filled[SlotOutW-1:0];
      if (rank > deepest) deepest = rank;
      filled++;
      return p;
    endfunction

    function void note_value(logic [InDataW-1:0] raw);
      pending_placements.push_back(place_value(raw));
    endfunction

    function int unsigned pending();
      return pending_placements.size();
    endfunction

    task report(string msg);
      if (errors < PrintMax) $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_placement(logic [OutDataW-1:0] data, logic flag);
      placement_t got;
      placement_t want;
      got = {flag, data};
      if (pending_placements.size() == 0) begin
        report($sformatf("result beat %h/%b with no value outstanding", data, flag));
        return;
      end
      want = pending_placements.pop_front();
      if (got.rank !== want.rank)
        report($sformatf("rank %0d, expected %0d", got.rank, want.rank));
      if (got.at_head !== want.at_head)
        report($sformatf("at_head %b, expected %b", got.at_head, want.at_head));
      if (got.pred_slot !== want.pred_slot)
        report($sformatf("pred_slot %0d, expected %0d", got.pred_slot, want.pred_slot));
      if (got.new_slot !== want.new_slot)
        report($sformatf("new_slot %0d, expected %0d", got.new_slot, want.new_slot));
      if (got.full_error !== want.full_error)
        report($sformatf("full_error %b, expected %b", got.full_error, want.full_error));
    endtask

    task close();
      if (pending_placements.size() != 0)
        report($sformatf("%0d results never arrived", pending_placements.size()));
    endtask
  endclass

endpackage

>>> tb/sv/tb_sorted_list_rank_insert.sv
// Top-level testbench for sorted_list_rank_insert: directed corner values, then random ones.
// Drives random gaps and stalls on both streams and checks every result beat.
// Depends on slri_pkg, tb_slri_board_pkg and the block's RTL.
module tb_sorted_list_rank_insert;
  timeunit 1ns;
  timeprecision 1ps;

  import slri_pkg::*;
  import tb_slri_board_pkg::*;

  localparam int unsigned ClkPeriod     = 10;
  localparam int unsigned ResetCycles   = 11;
  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned SettleCycles  = 1100;
  localparam int unsigned NumItems      = 580;
  localparam int unsigned NumDirected   = 18;
  localparam logic [InDataW-1:0] Directed [NumDirected] = '{
    32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
    32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
    32'h0000_0002, 32'hFFFF_FFFE, 32'h7FFF_FFFE, 32'h8000_0001, 32'h0000_0000,
    32'h0000_0003, 32'h0000_0001, 32'hFFFF_FFFF
  };

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;

  list_board          board = new();
  logic [InDataW-1:0] sent_values [$];
  int unsigned        idle_cycles = 0;
  bit                 sender_steady = 1'b0;

  sorted_list_rank_insert dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  function automatic int unsigned pick_gap(bit steady);
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [InDataW-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 35) return $urandom;
    if (r < 60) return InDataW'($signed($urandom_range(32)) - 16);
    if (r < 80 && sent_values.size() != 0)
      return sent_values[$urandom_range(sent_values.size() - 1)];
    case ($urandom_range(3))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  task automatic send_value(input logic [InDataW-1:0] value, input int unsigned gap);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    board.note_value(value);
    sent_values.push_back(value);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0);
  endtask

  // Result side: stall for a random gap, then take one beat.
  initial begin
    int unsigned gap;
    int unsigned beats;
    bit          steady;
    beats = 0;
    steady = 1'b0;
    forever begin
      if (beats % 40 == 0) steady = ($urandom_range(3) == 0);
      gap = pick_gap(steady);
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (m_axis_tvalid !== 1'b1);
      beats++;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) board.check_placement(m_axis_tdata, m_axis_tuser);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WatchdogLimit) begin
        $display("watchdog: no beat accepted for %0d cycles", WatchdogLimit);
        $display("TB_ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned count;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumDirected; i++) send_value(Directed[i], pick_gap(1'b0));
    wait_drained();

    count = 0;
    while (count < NumItems - NumDirected) begin
      if (count % 40 == 0) sender_steady = ($urandom_range(3) == 0);
      if ($urandom_range(99) == 0) wait_drained();
      send_value(pick_value(), pick_gap(sender_steady));
      count++;
    end
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);

    board.close();
    $display("Inserted %0d values into %0d slots, highest rank %0d.",
             board.filled, Capacity, board.deepest);
    $display("%0d values were refused with the store full.", board.refusals);
    if (board.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
